### src/c2s_pkg.sv
`timescale 1ns / 1ps

package c2s_pkg;

    // fraction bits added below the input lsb inside the cordic datapath
    localparam int GUARD_BITS = 4;

    // angle accumulator: binary angle, 2^31 equals pi, two bits of headroom
    localparam int ANGLE_W    = 34;
    localparam int ANGLE_FRAC = 16;
    localparam int ANGLE_OUT_W = 16;
    localparam int POLAR_FULL_W = ANGLE_W - ANGLE_FRAC;

    localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = ANGLE_W'(64'h0000_0000_8000_0000);
    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = ANGLE_W'(64'h0000_0000_4000_0000);
    localparam logic signed [ANGLE_W-1:0] ANGLE_ROUND   = ANGLE_W'(64'h0000_0000_0000_8000);

    localparam logic [ANGLE_OUT_W-1:0] POLAR_MAX = 16'h8000;

    // radius output format
    localparam int RADIUS_W = 17;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = 17'h1FFFF;

    // gain reciprocal is a Q32 unsigned constant
    localparam int RECIP_W    = 32;
    localparam int RECIP_FRAC = 32;

    // atan(2^-i) as binary angle, 2^31 equals pi
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // squared cordic gain over the given number of iterations, Q2.30
    function automatic logic [63:0] c2s_gain_k2(input int stages);
        logic [63:0] k;
        k = 64'd1 << 60;
        for (int i = 0; i < 32; i++)
        begin
            if (i < stages)
            begin
                k = k + (k >> (2 * i));
            end
        end
        k = k >> 30;
        if (k == 64'd0)
        begin
            k = 64'd1;
        end
        return k;
    endfunction

endpackage

### src/c2s_vec_if.sv
`timescale 1ns / 1ps

interface c2s_vec_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface

### src/c2s_sph_if.sv
`timescale 1ns / 1ps

interface c2s_sph_if;
    logic               valid;
    logic               ready;
    logic        [16:0] radius;
    logic        [15:0] polar_angle;
    logic signed [15:0] azimuth;
    logic               origin_flag;

    modport source (output valid, output radius, output polar_angle, output azimuth,
                    output origin_flag, input ready);
    modport sink   (input valid, input radius, input polar_angle, input azimuth,
                    input origin_flag, output ready);
endinterface

### src/cartesian_to_spherical_core.sv
`timescale 1ns / 1ps

// channel   dir  payload                                        handshake
// vec_in    in   x_coord, y_coord, z_coord (signed)              valid / ready
// sph_out   out  radius, polar_angle, azimuth, origin_flag       valid / ready
//
// fully pipelined: one vector per cycle while sph_out is not stalled, registered in order
// (input reg, azimuth cordic, prep, polar cordic, gain multiply, output reg)
// one pipeline enable: all stages advance when the output reg is empty or taken
// a stall freezes every stage in place, vec_in.ready follows the enable
// rst_n clears the valid bits only, datapath registers carry no reset

module cartesian_to_spherical_core
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    c2s_vec_if.sink           vec_in,
    c2s_sph_if.source         sph_out
);

    localparam int S      = CORDIC_STAGES;
    localparam int CW     = COORD_WIDTH + GUARD_BITS + 4;
    localparam int EXT_W  = CW - COORD_WIDTH - GUARD_BITS;
    localparam int MAG_W  = CW - 1;
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + RECIP_W;
    localparam int PHI_W  = HI_W + RECIP_W;
    localparam int RAD_SHIFT = RECIP_FRAC + GUARD_BITS;
    localparam int SUM_W  = (MAG_W + RECIP_W + 1 > RAD_SHIFT + RADIUS_W + 1) ?
                            (MAG_W + RECIP_W + 1) : (RAD_SHIFT + RADIUS_W + 1);

    localparam logic [63:0] GAIN_K2    = c2s_gain_k2(CORDIC_STAGES);
    localparam logic [63:0] RECIP_FULL = (64'd1 << 62) / GAIN_K2;
    localparam logic [RECIP_W-1:0] GAIN_RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [SUM_W-1:0]   RAD_ROUND  = SUM_W'(1) << (RAD_SHIFT - 1);

    // pipeline enable
    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || sph_out.ready;
    assign vec_in.ready = adv;

    // ------------------------------------------------------------------
    // pass one: azimuth, index 0 is the input register
    // ------------------------------------------------------------------
    logic signed [CW-1:0]          p1_x_reg    [S+1];
    logic signed [CW-1:0]          p1_y_reg    [S+1];
    logic signed [ANGLE_W-1:0]     p1_a_reg    [S+1];
    logic signed [COORD_WIDTH-1:0] p1_z_reg    [S+1];
    logic                          p1_v_reg    [S+1];
    logic                          p1_zero_reg [S+1];
    logic                          p1_xyz_reg  [S+1];

    logic signed [CW-1:0]      x_sc;
    logic signed [CW-1:0]      y_sc;
    logic signed [CW-1:0]      p1_x_next;
    logic signed [CW-1:0]      p1_y_next;
    logic signed [ANGLE_W-1:0] p1_a_next;
    logic                      xy_zero;

    // scale inputs and fold the left half plane onto the right
    always_comb
    begin
        x_sc = {{EXT_W{vec_in.x_coord[COORD_WIDTH-1]}}, vec_in.x_coord, {GUARD_BITS{1'b0}}};
        y_sc = {{EXT_W{vec_in.y_coord[COORD_WIDTH-1]}}, vec_in.y_coord, {GUARD_BITS{1'b0}}};
        xy_zero = (vec_in.x_coord == '0) && (vec_in.y_coord == '0);
        if (vec_in.x_coord[COORD_WIDTH-1])
        begin
            p1_x_next = -x_sc;
            p1_y_next = -y_sc;
            p1_a_next = vec_in.y_coord[COORD_WIDTH-1] ? -ANGLE_PI : ANGLE_PI;
        end
        else
        begin
            p1_x_next = x_sc;
            p1_y_next = y_sc;
            p1_a_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg[0] <= vec_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_x_reg[0]    <= p1_x_next;
            p1_y_reg[0]    <= p1_y_next;
            p1_a_reg[0]    <= p1_a_next;
            p1_z_reg[0]    <= vec_in.z_coord;
            p1_zero_reg[0] <= xy_zero && (vec_in.z_coord == '0);
            p1_xyz_reg[0]  <= xy_zero;
        end
    end

    // pass one vectoring iterations
    for (genvar i = 0; i < S; i++)
    begin : g_pass1
        logic signed [CW-1:0]      dx;
        logic signed [CW-1:0]      dy;
        logic signed [ANGLE_W-1:0] step;
        logic signed [CW-1:0]      x_next;
        logic signed [CW-1:0]      y_next;
        logic signed [ANGLE_W-1:0] a_next;

        always_comb
        begin
            dx   = p1_y_reg[i] >>> i;
            dy   = p1_x_reg[i] >>> i;
            step = ANGLE_W'(ATAN_TAB[i]);
            if (!p1_y_reg[i][CW-1])
            begin
                x_next = p1_x_reg[i] + dx;
                y_next = p1_y_reg[i] - dy;
                a_next = p1_a_reg[i] + step;
            end
            else
            begin
                x_next = p1_x_reg[i] - dx;
                y_next = p1_y_reg[i] + dy;
                a_next = p1_a_reg[i] - step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p1_v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                p1_v_reg[i+1] <= p1_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p1_x_reg[i+1]    <= x_next;
                p1_y_reg[i+1]    <= y_next;
                p1_a_reg[i+1]    <= a_next;
                p1_z_reg[i+1]    <= p1_z_reg[i];
                p1_zero_reg[i+1] <= p1_zero_reg[i];
                p1_xyz_reg[i+1]  <= p1_xyz_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // pass two: polar angle and magnitude, index 0 is the prep register
    // ------------------------------------------------------------------
    logic signed [CW-1:0]          p2_x_reg    [S+1];
    logic signed [CW-1:0]          p2_y_reg    [S+1];
    logic signed [ANGLE_W-1:0]     p2_a_reg    [S+1];
    logic signed [ANGLE_OUT_W-1:0] p2_az_reg   [S+1];
    logic                          p2_v_reg    [S+1];
    logic                          p2_zero_reg [S+1];

    logic signed [CW-1:0]          z_sc;
    logic signed [ANGLE_W-1:0]     az_sum;
    logic signed [ANGLE_OUT_W-1:0] az_next;
    logic signed [CW-1:0]          p2_x_next;
    logic signed [CW-1:0]          p2_y_next;
    logic signed [ANGLE_W-1:0]     p2_a_next;

    // round the azimuth and set up the (z, rho) vector
    always_comb
    begin
        az_sum  = p1_a_reg[S] + ANGLE_ROUND;
        az_next = p1_xyz_reg[S] ? '0 : az_sum[ANGLE_FRAC+ANGLE_OUT_W-1:ANGLE_FRAC];
        z_sc    = {{EXT_W{p1_z_reg[S][COORD_WIDTH-1]}}, p1_z_reg[S], {GUARD_BITS{1'b0}}};
        if (p1_z_reg[S][COORD_WIDTH-1])
        begin
            p2_x_next = p1_x_reg[S];
            p2_y_next = -z_sc;
            p2_a_next = ANGLE_HALF_PI;
        end
        else
        begin
            p2_x_next = z_sc;
            p2_y_next = p1_x_reg[S];
            p2_a_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            p2_v_reg[0] <= p1_v_reg[S];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_x_reg[0]    <= p2_x_next;
            p2_y_reg[0]    <= p2_y_next;
            p2_a_reg[0]    <= p2_a_next;
            p2_az_reg[0]   <= az_next;
            p2_zero_reg[0] <= p1_zero_reg[S];
        end
    end

    // pass two vectoring iterations
    for (genvar i = 0; i < S; i++)
    begin : g_pass2
        logic signed [CW-1:0]      dx;
        logic signed [CW-1:0]      dy;
        logic signed [ANGLE_W-1:0] step;
        logic signed [CW-1:0]      x_next;
        logic signed [CW-1:0]      y_next;
        logic signed [ANGLE_W-1:0] a_next;

        always_comb
        begin
            dx   = p2_y_reg[i] >>> i;
            dy   = p2_x_reg[i] >>> i;
            step = ANGLE_W'(ATAN_TAB[i]);
            if (!p2_y_reg[i][CW-1])
            begin
                x_next = p2_x_reg[i] + dx;
                y_next = p2_y_reg[i] - dy;
                a_next = p2_a_reg[i] + step;
            end
            else
            begin
                x_next = p2_x_reg[i] - dx;
                y_next = p2_y_reg[i] + dy;
                a_next = p2_a_reg[i] - step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p2_v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                p2_v_reg[i+1] <= p2_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p2_x_reg[i+1]    <= x_next;
                p2_y_reg[i+1]    <= y_next;
                p2_a_reg[i+1]    <= a_next;
                p2_az_reg[i+1]   <= p2_az_reg[i];
                p2_zero_reg[i+1] <= p2_zero_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // gain correction: two partial products of magnitude times 1/K^2
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0]      pol_sum;
    logic signed [POLAR_FULL_W-1:0] pol_full;
    logic [ANGLE_OUT_W-1:0]         pol_next;
    logic [MAG_W-1:0]               mag;
    logic [PHI_W-1:0]               prod_hi_next;
    logic [PLO_W-1:0]               prod_lo_next;

    logic                          mul_v_reg;
    logic                          mul_zero_reg;
    logic [ANGLE_OUT_W-1:0]        mul_pol_reg;
    logic signed [ANGLE_OUT_W-1:0] mul_az_reg;
    logic [PHI_W-1:0]              prod_hi_reg;
    logic [PLO_W-1:0]              prod_lo_reg;

    // round and clamp the polar angle, split the magnitude
    always_comb
    begin
        pol_sum  = p2_a_reg[S] + ANGLE_ROUND;
        pol_full = pol_sum[ANGLE_W-1:ANGLE_FRAC];
        if (pol_full[POLAR_FULL_W-1])
        begin
            pol_next = '0;
        end
        else if (pol_full > $signed({{(POLAR_FULL_W-ANGLE_OUT_W){1'b0}}, POLAR_MAX}))
        begin
            pol_next = POLAR_MAX;
        end
        else
        begin
            pol_next = pol_full[ANGLE_OUT_W-1:0];
        end
        mag = (p2_x_reg[S] > 0) ? p2_x_reg[S][MAG_W-1:0] : '0;
        prod_hi_next = PHI_W'(mag[MAG_W-1:LO_W]) * PHI_W'(GAIN_RECIP);
        prod_lo_next = PLO_W'(mag[LO_W-1:0]) * PLO_W'(GAIN_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_v_reg <= p2_v_reg[S];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_zero_reg <= p2_zero_reg[S];
            mul_pol_reg  <= pol_next;
            mul_az_reg   <= p2_az_reg[S];
            prod_hi_reg  <= prod_hi_next;
            prod_lo_reg  <= prod_lo_next;
        end
    end

    // ------------------------------------------------------------------
    // output register: sum, round, saturate, origin override
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]              rad_sum;
    logic [RADIUS_W-1:0]           rad_next;
    logic [RADIUS_W-1:0]           radius_reg;
    logic [ANGLE_OUT_W-1:0]        polar_reg;
    logic signed [ANGLE_OUT_W-1:0] azimuth_reg;
    logic                          origin_reg;

    always_comb
    begin
        rad_sum = (SUM_W'(prod_hi_reg) << LO_W) + SUM_W'(prod_lo_reg) + RAD_ROUND;
        if (|rad_sum[SUM_W-1:RAD_SHIFT+RADIUS_W])
        begin
            rad_next = RADIUS_MAX;
        end
        else
        begin
            rad_next = rad_sum[RAD_SHIFT+RADIUS_W-1:RAD_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mul_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            radius_reg  <= mul_zero_reg ? '0 : rad_next;
            polar_reg   <= mul_zero_reg ? '0 : mul_pol_reg;
            azimuth_reg <= mul_zero_reg ? '0 : mul_az_reg;
            origin_reg  <= mul_zero_reg;
        end
    end

    assign sph_out.valid       = out_valid_reg;
    assign sph_out.radius      = radius_reg;
    assign sph_out.polar_angle = polar_reg;
    assign sph_out.azimuth     = azimuth_reg;
    assign sph_out.origin_flag = origin_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // origin result carries all-zero radius and angles
    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sph_out.valid && sph_out.origin_flag) |->
            (sph_out.radius == '0 && sph_out.polar_angle == '0 && sph_out.azimuth == '0))
        else $error("origin result with nonzero fields");

    // polar angle never leaves 0..pi
    a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
        sph_out.valid |-> (sph_out.polar_angle <= POLAR_MAX))
        else $error("polar angle above pi");

    // a stalled output blocks the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (sph_out.valid && !sph_out.ready) |-> !vec_in.ready)
        else $error("input accepted while output stalled");

    // a held result keeps its payload across the stall
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sph_out.valid && !sph_out.ready) |=>
            (sph_out.valid && $stable(sph_out.radius) && $stable(sph_out.polar_angle)
             && $stable(sph_out.azimuth)))
        else $error("output changed during stall");

endmodule

### sim/tb_cartesian_to_spherical_core.sv
`timescale 1ns / 1ps

module tb_cartesian_to_spherical_core;

    import c2s_pkg::RADIUS_W;
    import c2s_pkg::ANGLE_OUT_W;
    import c2s_pkg::RADIUS_MAX;
    import c2s_pkg::POLAR_MAX;

    localparam int COORD_W       = 16;
    localparam int STAGE_COUNT   = 16;
    localparam int FRAC_GUARD    = 4;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_AT_ITEM  = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 2 * STAGE_COUNT + 20;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIR_ROWS      = 25;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } vec_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]           radius;
        logic [ANGLE_OUT_W-1:0]        polar_angle;
        logic signed [ANGLE_OUT_W-1:0] azimuth;
        logic                          origin_flag;
    } sph_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic                      typed;
        sph_t                      want;
    } dir_row_t;

    // atan(2^-i), binary angle with 2^31 = pi
    localparam longint ATAN_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    localparam logic signed [COORD_W-1:0] EDGE_VALS [5] = '{
        16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff
    };

    localparam sph_t ORIGIN_RESULT = '{17'd0, 16'd0, 16'sd0, 1'b1};

    // directed table: typed expectation only for the origin rows
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{16'sd0,     16'sd0,     16'sd0,     1'b1, ORIGIN_RESULT},
        '{16'sh7fff,  16'sd0,     16'sd0,     1'b0, '0},
        '{16'sh8000,  16'sd0,     16'sd0,     1'b0, '0},
        '{16'sh8000,  -16'sd1,    16'sd0,     1'b0, '0},
        '{-16'sd1,    16'sd0,     16'sd0,     1'b0, '0},
        '{16'sd0,     16'sh7fff,  16'sd0,     1'b0, '0},
        '{16'sd0,     16'sh8000,  16'sd0,     1'b0, '0},
        '{16'sd0,     16'sd0,     16'sh7fff,  1'b0, '0},
        '{16'sd0,     16'sd0,     16'sh8000,  1'b0, '0},
        '{16'sh7fff,  16'sh7fff,  16'sh7fff,  1'b0, '0},
        '{16'sh8000,  16'sh8000,  16'sh8000,  1'b0, '0},
        '{16'sd1,     16'sd0,     16'sd0,     1'b0, '0},
        '{16'sd0,     16'sd0,     16'sd1,     1'b0, '0},
        '{16'sd0,     16'sd0,     -16'sd1,    1'b0, '0},
        '{-16'sd1,    -16'sd1,    -16'sd1,    1'b0, '0},
        '{16'sd1,     16'sd1,     16'sd1,     1'b0, '0},
        '{16'sh8000,  16'sh7fff,  16'sh8000,  1'b0, '0},
        '{16'sh7fff,  16'sh8000,  16'sh7fff,  1'b0, '0},
        '{16'sd0,     16'sd1,     16'sd0,     1'b0, '0},
        '{16'sd0,     -16'sd1,    16'sd0,     1'b0, '0},
        '{-16'sd1,    16'sd0,     16'sd5,     1'b0, '0},
        '{16'sd0,     16'sd0,     16'sd0,     1'b1, ORIGIN_RESULT},
        '{16'sd1,     -16'sd1,    16'sd0,     1'b0, '0},
        '{16'sd12345, -16'sd6789, -16'sd4321, 1'b0, '0},
        '{-16'sd5,    16'sd3,     16'sd0,     1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    c2s_vec_if #(.COORD_WIDTH(COORD_W)) vec_if ();
    c2s_sph_if                          sph_if ();

    cartesian_to_spherical_core #(
        .COORD_WIDTH   (COORD_W),
        .CORDIC_STAGES (STAGE_COUNT)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vec_in  (vec_if),
        .sph_out (sph_if)
    );

    sph_t pending_spherical [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    bit   hold_request   = 1'b0;
    bit   hold_done      = 1'b0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("cartesian_to_spherical_core verification failed");
            $finish;
        end
    end

    // one vectoring pass: rotate (vx, vy) onto the positive x axis
    function automatic void rotate_onto_axis(inout longint vx, inout longint vy,
                                             inout longint ang);
        longint dx;
        longint dy;
        int     i;
        for (i = 0; i < STAGE_COUNT; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + ATAN_STEP[i];
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - ATAN_STEP[i];
            end
        end
    endfunction

    // expected spherical form of one vector
    function automatic sph_t predict_spherical(vec_t v);
        longint          x, y, z;
        longint          ax, ay, aa, bx, by, ba, pol, az;
        longint unsigned gain, recip, mag, rad;
        sph_t            res;
        int              i;
        x = longint'($signed(v.x_coord));
        y = longint'($signed(v.y_coord));
        z = longint'($signed(v.z_coord));
        if (x == 0 && y == 0 && z == 0)
        begin
            return ORIGIN_RESULT;
        end

        // azimuth pass, left half plane folded over with a pi start
        ax = x * (64'sd1 <<< FRAC_GUARD);
        ay = y * (64'sd1 <<< FRAC_GUARD);
        aa = 0;
        if (ax < 0)
        begin
            aa = (ay >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            ax = -ax;
            ay = -ay;
        end
        rotate_onto_axis(ax, ay, aa);
        az = (x == 0 && y == 0) ? 64'sd0 : ((aa + 32768) >>> 16);

        // polar pass, negative z starts at half pi
        if (z < 0)
        begin
            bx = ax;
            by = -z * (64'sd1 <<< FRAC_GUARD);
            ba = 64'sd1 <<< 30;
        end
        else
        begin
            bx = z * (64'sd1 <<< FRAC_GUARD);
            by = ax;
            ba = 0;
        end
        rotate_onto_axis(bx, by, ba);
        pol = (ba + 32768) >>> 16;
        if (pol < 0)
        begin
            pol = 0;
        end
        if (pol > longint'(POLAR_MAX))
        begin
            pol = longint'(POLAR_MAX);
        end

        // squared gain built in Q2.60 and cut to Q2.30, reciprocal in Q32
        gain = 64'd1 << 60;
        for (i = 0; i < STAGE_COUNT; i++)
        begin
            gain = gain + (gain >> (2 * i));
        end
        gain = gain >> 30;
        if (gain == 0)
        begin
            gain = 1;
        end
        recip = (64'd1 << 62) / gain;

        // gain correction with rounding, then saturation
        mag = (bx > 0) ? longint'(bx) : 64'd0;
        rad = (mag >> 16) * recip
            + (((mag & 64'hFFFF) * recip + (64'd1 << (31 + FRAC_GUARD))) >> 16);
        rad = rad >> (16 + FRAC_GUARD);
        if (rad > longint'(RADIUS_MAX))
        begin
            rad = longint'(RADIUS_MAX);
        end

        res.radius      = rad[RADIUS_W-1:0];
        res.polar_angle = pol[ANGLE_OUT_W-1:0];
        res.azimuth     = az[ANGLE_OUT_W-1:0];
        res.origin_flag = 1'b0;
        return res;
    endfunction

    // idle cycles before the next transaction, with calm stretches of none
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 10);
    endfunction

    int sender_calm = 0;

    // offer one vector and record its expected result on acceptance
    task automatic offer_vector(input vec_t v, input sph_t want);
        int gap;
        bit fire;
        gap = draw_gap(sender_calm);
        if (gap > 0)
        begin
            vec_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_if.valid   <= 1'b1;
        vec_if.x_coord <= v.x_coord;
        vec_if.y_coord <= v.y_coord;
        vec_if.z_coord <= v.z_coord;
        forever
        begin
            @(negedge clk);
            fire = vec_if.ready;
            @(posedge clk);
            if (fire)
            begin
                break;
            end
        end
        pending_spherical.push_back(want);
    endtask

    // stimulus: directed table, then random vectors
    initial
    begin : stimulus
        vec_t v;
        sph_t want;
        int   n;
        rst_n          <= 1'b0;
        vec_if.valid   <= 1'b0;
        vec_if.x_coord <= '0;
        vec_if.y_coord <= '0;
        vec_if.z_coord <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIR_ROWS; n++)
        begin
            v.x_coord = DIRECTED[n].x_coord;
            v.y_coord = DIRECTED[n].y_coord;
            v.z_coord = DIRECTED[n].z_coord;
            want = DIRECTED[n].typed ? DIRECTED[n].want : predict_spherical(v);
            offer_vector(v, want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT_ITEM)
            begin
                hold_request = 1'b1;
            end
            v.x_coord = COORD_W'($urandom);
            v.y_coord = COORD_W'($urandom);
            v.z_coord = COORD_W'($urandom);
            case ($urandom_range(0, 9))
                5, 6:
                begin
                    // small magnitudes, where rounding dominates
                    v.x_coord = COORD_W'(int'($urandom_range(0, 128)) - 64);
                    v.y_coord = COORD_W'(int'($urandom_range(0, 128)) - 64);
                    v.z_coord = COORD_W'(int'($urandom_range(0, 128)) - 64);
                end
                7:
                begin
                    // some components zeroed
                    if ($urandom_range(0, 1)) v.x_coord = '0;
                    if ($urandom_range(0, 1)) v.y_coord = '0;
                    if ($urandom_range(0, 1)) v.z_coord = '0;
                end
                8:
                begin
                    v.x_coord = EDGE_VALS[$urandom_range(0, 4)];
                    v.y_coord = EDGE_VALS[$urandom_range(0, 4)];
                    v.z_coord = EDGE_VALS[$urandom_range(0, 4)];
                end
                9:
                begin
                    // origin, or a point on the z axis
                    v.x_coord = '0;
                    v.y_coord = '0;
                    if ($urandom_range(0, 1)) v.z_coord = '0;
                end
                default:
                begin
                end
            endcase
            offer_vector(v, predict_spherical(v));
        end
        vec_if.valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending_spherical.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_spherical.size() == 0)
        begin
            $display("cartesian_to_spherical_core verification clean");
        end
        else
        begin
            $display("cartesian_to_spherical_core verification failed");
        end
        $finish;
    end

    // result side: random back-pressure, one long hold, compare with oldest expectation
    initial
    begin : result_sink
        int   gap;
        int   sink_calm;
        bit   fire;
        sph_t got;
        sph_t want;
        sink_calm     = 0;
        sph_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
            begin
                gap = draw_gap(sink_calm);
            end
            if (gap > 0)
            begin
                sph_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sph_if.ready <= 1'b1;
            forever
            begin
                @(negedge clk);
                fire            = sph_if.valid;
                got.radius      = sph_if.radius;
                got.polar_angle = sph_if.polar_angle;
                got.azimuth     = sph_if.azimuth;
                got.origin_flag = sph_if.origin_flag;
                @(posedge clk);
                if (fire)
                begin
                    break;
                end
            end

            // check the transaction
            if (pending_spherical.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result: radius %0d polar %0d azimuth %0d origin %0b",
                             got.radius, got.polar_angle, $signed(got.azimuth),
                             got.origin_flag);
                end
            end
            else
            begin
                want = pending_spherical.pop_front();
                if (got.radius !== want.radius || got.polar_angle !== want.polar_angle
                    || got.azimuth !== want.azimuth || got.origin_flag !== want.origin_flag)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected radius %0d polar %0d azimuth %0d origin %0b",
                                 want.radius, want.polar_angle, $signed(want.azimuth),
                                 want.origin_flag);
                        $display("          actual   radius %0d polar %0d azimuth %0d origin %0b",
                                 got.radius, got.polar_angle, $signed(got.azimuth),
                                 got.origin_flag);
                    end
                end
            end
        end
    end

endmodule
